[rtl/signal_edge_taper_top_assert.svh]
// Assertion macros for the verification files of the edge taper block.
`ifndef SIGNAL_EDGE_TAPER_TOP_ASSERT_SVH
`define SIGNAL_EDGE_TAPER_TOP_ASSERT_SVH

// Checks a property while reset is released.
`define SET_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Checks a property at every clock edge, including during reset.
`define SET_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: property failed");

`endif

[rtl/set_pkg.sv]
package set_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned COEF_F     = 16;
  localparam int unsigned COEF_W     = COEF_F + 1;
  localparam int unsigned D3_W       = 49;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  localparam int unsigned HANN_T_W   = 30;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned TAY_N      = 9;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LEN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SPAN     = 2'd2;

  localparam logic [LEN_W-1:0]  MAX_RECORD = 17'd65536;
  localparam logic [COEF_W-1:0] COEF_ONE   = {1'b1, {COEF_F{1'b0}}};

  localparam int unsigned RATIO_LAT = 4 + COEF_W;
  localparam int unsigned HANN_LAT  = HANN_T_W + 3 + 3 * TAY_N + 2;
  localparam int unsigned COEF_LAT  = HANN_LAT;
  localparam int unsigned RATIO_PAD = COEF_LAT - RATIO_LAT;
  localparam int unsigned PIPE_DEPTH = COEF_LAT + 4;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

  localparam logic [8:0] TAYLOR_DIV [TAY_N] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342
  };

  localparam logic [31:0] TAYLOR_RECIP [TAY_N] = '{
    32'((64'd1 << 33) / 64'd6),   32'((64'd1 << 33) / 64'd20),
    32'((64'd1 << 33) / 64'd42),  32'((64'd1 << 33) / 64'd72),
    32'((64'd1 << 33) / 64'd110), 32'((64'd1 << 33) / 64'd156),
    32'((64'd1 << 33) / 64'd210), 32'((64'd1 << 33) / 64'd272),
    32'((64'd1 << 33) / 64'd342)
  };

  typedef enum logic [TYPE_W-1:0] {
    WIN_BARTLETT = 2'd0,
    WIN_HANN     = 2'd1,
    WIN_PARZEN   = 2'd2,
    WIN_NONE     = 2'd3
  } window_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           position;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] tapered_sample;
  } out_beat_t;

endpackage

[rtl/set_stream_if.sv]
interface set_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/signal_edge_taper_top.sv]
// Channel  Direction  Beat contents
// in_i     sink       sample, position
// out_o    source     tapered_sample
// cfg      write      window_type, record_length, edge_span
//
// One beat enters per cycle while no beat is held at the output; a new beat can enter before earlier beats leave.
// The pipeline depth is set by the Hann path: a 30-step divider and nine Taylor steps of three
// stages each; the ratio paths are delayed to line up with it.
// Reset clears the valid bits and loads the configuration registers with their defaults.
// A beat held at the output freezes every stage; in_i.ready is low only then.
module signal_edge_taper_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  set_stream_if.sink                     in_i,
  set_stream_if.source                   out_o,
  input  logic                           cfg_we_i,
  input  logic [set_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [set_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import set_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       front;
    logic                       back;
    logic                       hann;
  } item_t;

  window_e             win_type_q;
  logic [LEN_W-1:0]    rec_len_q;
  logic [LEN_W-1:0]    tap_len_q;
  logic [LEN_W-1:0]    rec_eff_c;
  logic [LEN_W-1:0]    tap_eff_c;
  logic [LEN_W-1:0]    den_c;
  logic [LEN_W-1:0]    pos_c;
  logic [LEN_W-1:0]    kidx_c;
  logic                front_c;
  logic                back_c;
  logic [LEN_W-1:0]    l_q;
  logic [LEN_W-1:0]    d_q;
  logic [2*LEN_W-1:0]  dd_q;
  logic [D3_W-1:0]     d3_q;
  logic [PIPE_DEPTH-1:0] v_q;
  logic                en;
  item_t               pipe_q [COEF_LAT+1];
  logic [POS_W-1:0]    j_q;
  logic [POS_W-1:0]    k_q;
  logic                parzen_q;
  logic [COEF_W-1:0]   ratio_f;
  logic [COEF_W-1:0]   ratio_b;
  logic [COEF_W-1:0]   hann_c;
  logic [COEF_W-1:0]   rf_q [RATIO_PAD];
  logic [COEF_W-1:0]   rb_q [RATIO_PAD];
  item_t               it;
  logic [COEF_W-1:0]   cf_c;
  logic [COEF_W-1:0]   cb_c;
  logic [SAMPLE_W-1:0] mag_c;
  logic [PROD_W-1:0]   m1_prod_q;
  logic [COEF_W-1:0]   m1_cb_q;
  logic                m1_neg_q;
  logic [PROD_W-1:0]   rnd1;
  logic [PROD_W-1:0]   m2_prod_q;
  logic                m2_neg_q;
  logic [PROD_W-1:0]   rnd2;
  logic [SAMPLE_W-1:0] mag2;
  logic [SAMPLE_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_type_q <= WIN_NONE;
      rec_len_q  <= MAX_RECORD;
      tap_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_TYPE:   win_type_q <= window_e'(cfg_data_i[TYPE_W-1:0]);
        CFG_RECORD_LENGTH: rec_len_q  <= cfg_data_i;
        CFG_EDGE_SPAN:     tap_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rec_eff_c = (rec_len_q > MAX_RECORD) ? MAX_RECORD : rec_len_q;
  assign tap_eff_c = (tap_len_q > rec_eff_c) ? rec_eff_c : tap_len_q;
  assign den_c     = tap_eff_c + LEN_W'(1);

  always_ff @(posedge clk_i) begin
    l_q  <= tap_eff_c;
    d_q  <= den_c;
    dd_q <= (2*LEN_W)'(den_c) * (2*LEN_W)'(den_c);
    d3_q <= D3_W'((3*LEN_W)'(dd_q) * (3*LEN_W)'(d_q));
  end

  assign pos_c   = {1'b0, in_i.data.position};
  assign kidx_c  = rec_eff_c - pos_c - LEN_W'(1);
  assign front_c = (win_type_q != WIN_NONE) && (tap_eff_c != '0) && (pos_c < tap_eff_c);
  assign back_c  = (win_type_q != WIN_NONE) && (win_type_q != WIN_HANN) &&
                   (tap_eff_c != '0) && (pos_c < rec_eff_c) &&
                   (pos_c >= rec_eff_c - tap_eff_c);

  assign en         = !v_q[PIPE_DEPTH-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= '{sample: in_i.data.sample, front: front_c, back: back_c,
                     hann: win_type_q == WIN_HANN};
      j_q       <= in_i.data.position;
      k_q       <= kidx_c[POS_W-1:0];
      parzen_q  <= win_type_q == WIN_PARZEN;
      for (int unsigned i = 1; i <= COEF_LAT; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
      rf_q[0] <= ratio_f;
      rb_q[0] <= ratio_b;
      for (int unsigned i = 1; i < RATIO_PAD; i++) begin
        rf_q[i] <= rf_q[i-1];
        rb_q[i] <= rb_q[i-1];
      end
    end
  end

  set_ratio u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .parzen_i (parzen_q),
    .idx_i    (j_q),
    .len_i    (l_q),
    .den_i    (d_q),
    .den3_i   (d3_q),
    .coef_o   (ratio_f)
  );

  set_ratio u_back (
    .clk_i    (clk_i),
    .en_i     (en),
    .parzen_i (parzen_q),
    .idx_i    (k_q),
    .len_i    (l_q),
    .den_i    (d_q),
    .den3_i   (d3_q),
    .coef_o   (ratio_b)
  );

  set_hann u_hann (
    .clk_i  (clk_i),
    .en_i   (en),
    .idx_i  (j_q),
    .den_i  (d_q),
    .coef_o (hann_c)
  );

  assign it    = pipe_q[COEF_LAT];
  assign cf_c  = !it.front ? COEF_ONE : (it.hann ? hann_c : rf_q[RATIO_PAD-1]);
  assign cb_c  = it.back ? rb_q[RATIO_PAD-1] : COEF_ONE;
  assign mag_c = it.sample[SAMPLE_W-1] ? $unsigned(-it.sample) : $unsigned(it.sample);
  assign rnd1  = m1_prod_q + (PROD_W'(1) << (COEF_F - 1));
  assign rnd2  = m2_prod_q + (PROD_W'(1) << (COEF_F - 1));
  assign mag2  = rnd2[COEF_F +: SAMPLE_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_prod_q <= PROD_W'(mag_c) * PROD_W'(cf_c);
      m1_cb_q   <= cb_c;
      m1_neg_q  <= it.sample[SAMPLE_W-1];
      m2_prod_q <= PROD_W'(rnd1[COEF_F +: SAMPLE_W]) * PROD_W'(m1_cb_q);
      m2_neg_q  <= m1_neg_q;
      out_q     <= m2_neg_q ? (~mag2) + SAMPLE_W'(1) : mag2;
    end
  end

  assign out_o.valid               = v_q[PIPE_DEPTH-1];
  assign out_o.data.tapered_sample = $signed(out_q);
endmodule

[rtl/set_div.sv]
module set_div #(
  parameter int unsigned DW = set_pkg::D3_W,
  parameter int unsigned QW = set_pkg::COEF_W
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] q_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o
);
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] dv_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   shl;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign dv_in  = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dv_in  = dv_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign shl  = {rem_in, 1'b0};
    assign diff = shl - {1'b0, dv_in};
    assign ge   = shl >= {1'b0, dv_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DW-1:0] : shl[DW-1:0];
        quo_q[s] <= QW'({quo_in, ge});
        dv_q[s]  <= dv_in;
      end
    end
  end

  assign q_o   = quo_q[QW-1];
  assign rem_o = rem_q[QW-1];
  assign den_o = dv_q[QW-1];
endmodule

[rtl/set_ratio.sv]
module set_ratio (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       parzen_i,
  input  logic [set_pkg::POS_W-1:0]  idx_i,
  input  logic [set_pkg::LEN_W-1:0]  len_i,
  input  logic [set_pkg::LEN_W-1:0]  den_i,
  input  logic [set_pkg::D3_W-1:0]   den3_i,
  output logic [set_pkg::COEF_W-1:0] coef_o
);
  import set_pkg::*;

  logic [POS_W-1:0]   p1_idx_q;
  logic [2*POS_W-1:0] p1_sq_q;
  logic [LEN_W-1:0]   p1_e_q;
  logic [2*LEN_W-1:0] p1_esq_q;
  logic               p1_lo_q;
  logic               p1_parzen_q;
  logic [POS_W-1:0]   p2_idx_q;
  logic [D3_W-1:0]    p2_a_q;
  logic [D3_W-1:0]    p2_b_q;
  logic               p2_lo_q;
  logic               p2_parzen_q;
  logic [D3_W-1:0]    num_q;
  logic [D3_W-1:0]    den_q;
  logic [LEN_W-1:0]   e_c;
  logic [D3_W-1:0]    num_c;
  logic [COEF_W-1:0]  quo;
  logic [D3_W-1:0]    rem_unused;
  logic [D3_W-1:0]    den_out;
  logic [COEF_W:0]    quo_inc;
  logic [COEF_W-1:0]  coef_q;

  assign e_c = den_i - {1'b0, idx_i};

  always_comb begin
    if (!p2_parzen_q) begin
      num_c = D3_W'(p2_idx_q);
    end else if (p2_lo_q) begin
      num_c = D3_W'({p2_a_q, 2'b00}) + D3_W'({p2_a_q, 1'b0});
    end else begin
      num_c = den3_i - D3_W'({p2_b_q, 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_idx_q    <= idx_i;
      p1_sq_q     <= (2*POS_W)'(idx_i) * (2*POS_W)'(idx_i);
      p1_e_q      <= e_c;
      p1_esq_q    <= (2*LEN_W)'(e_c) * (2*LEN_W)'(e_c);
      p1_lo_q     <= {idx_i, 1'b0} <= den_i;
      p1_parzen_q <= parzen_i;
      p2_idx_q    <= p1_idx_q;
      p2_a_q      <= D3_W'(p1_sq_q) * D3_W'(p1_e_q);
      p2_b_q      <= D3_W'((3*LEN_W)'(p1_esq_q) * (3*LEN_W)'(p1_e_q));
      p2_lo_q     <= p1_lo_q;
      p2_parzen_q <= p1_parzen_q;
      num_q       <= num_c;
      den_q       <= p2_parzen_q ? den3_i : D3_W'(len_i);
      coef_q      <= quo_inc[COEF_W:1];
    end
  end

  set_div #(
    .DW(D3_W),
    .QW(COEF_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (den_q),
    .q_o   (quo),
    .rem_o (rem_unused),
    .den_o (den_out)
  );

  assign quo_inc = {1'b0, quo} + (COEF_W+1)'(1);
  assign coef_o  = coef_q;
endmodule

[rtl/set_hann.sv]
module set_hann (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [set_pkg::POS_W-1:0]  idx_i,
  input  logic [set_pkg::LEN_W-1:0]  den_i,
  output logic [set_pkg::COEF_W-1:0] coef_o
);
  import set_pkg::*;

  logic [HANN_T_W-1:0]     quo;
  logic [LEN_W-1:0]        rem;
  logic [LEN_W-1:0]        dv;
  logic [LEN_W:0]          half_sum;
  logic [HANN_T_W-1:0]     t_q;
  logic [60:0]             ang_prod;
  logic [30:0]             a_q;
  logic [61:0]             asq;
  logic [31:0]             tm_q [TAY_N];
  logic [31:0]             aa_q [TAY_N];
  logic signed [SUM_W-1:0] sm_q [TAY_N+1];
  logic [63:0]             px_q [TAY_N];
  logic signed [SUM_W-1:0] sx_q [TAY_N];
  logic [31:0]             ax_q [TAY_N];
  logic [31:0]             xy_q [TAY_N];
  logic [63:0]             yy_q [TAY_N];
  logic signed [SUM_W-1:0] sy_q [TAY_N];
  logic [31:0]             ay_q [TAY_N];
  logic signed [SUM_W-1:0] sum_fin;
  logic [30:0]             s_c;
  logic [61:0]             h_q;
  logic [61:0]             h_rnd;
  logic [COEF_W-1:0]       coef_q;

  set_div #(
    .DW(LEN_W),
    .QW(HANN_T_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i ({1'b0, idx_i}),
    .den_i (den_i),
    .q_o   (quo),
    .rem_o (rem),
    .den_o (dv)
  );

  assign half_sum = {1'b0, rem} + {2'b00, dv[LEN_W-1:1]};
  assign ang_prod = 61'(t_q) * 61'(HALF_PI_Q30) + 61'(Q30_HALF);
  assign asq      = 62'(a_q) * 62'(a_q) + 62'(Q30_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= quo + HANN_T_W'(half_sum >= {1'b0, dv});
      a_q      <= ang_prod[60:30];
      aa_q[0]  <= asq[61:30];
      tm_q[0]  <= 32'(a_q);
      sm_q[0]  <= SUM_W'(a_q);
    end
  end

  for (genvar k = 0; k < TAY_N; k++) begin : g_tay
    localparam bit SUB = (k % 2) == 0;
    logic [63:0] rnd;
    logic [40:0] q0;
    logic [40:0] prod;
    logic [40:0] rest;
    logic [31:0] term;

    assign rnd  = px_q[k] + Q30_HALF;
    assign q0   = 41'(yy_q[k][63:33]);
    assign prod = q0 * 41'(TAYLOR_DIV[k]);
    assign rest = 41'(xy_q[k]) - prod;
    assign term = (rest >= 41'(TAYLOR_DIV[k])) ? 32'(q0) + 32'd1 : 32'(q0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        px_q[k] <= 64'(tm_q[k]) * 64'(aa_q[k]);
        sx_q[k] <= sm_q[k];
        ax_q[k] <= aa_q[k];
        xy_q[k] <= rnd[61:30];
        yy_q[k] <= 64'(rnd[61:30]) * 64'(TAYLOR_RECIP[k]);
        sy_q[k] <= sx_q[k];
        ay_q[k] <= ax_q[k];
        if (SUB) begin
          sm_q[k+1] <= sy_q[k] - $signed({2'b00, term});
        end else begin
          sm_q[k+1] <= sy_q[k] + $signed({2'b00, term});
        end
      end
    end

    if (k < TAY_N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tm_q[k+1] <= term;
          aa_q[k+1] <= ay_q[k];
        end
      end
    end
  end

  assign sum_fin = sm_q[TAY_N];

  always_comb begin
    if (sum_fin < 0) begin
      s_c = '0;
    end else if (sum_fin > $signed(SUM_W'(64'd1 << 30))) begin
      s_c = 31'd1 << 30;
    end else begin
      s_c = sum_fin[30:0];
    end
  end

  assign h_rnd = h_q + (62'd1 << (59 - COEF_F));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q    <= 62'(s_c) * 62'(s_c);
      coef_q <= h_rnd[60-COEF_F +: COEF_W];
    end
  end

  assign coef_o = coef_q;
endmodule

[rtl/set_checker.sv]
`include "signal_edge_taper_top_assert.svh"

module set_checker (
  input logic          clk_i,
  input logic          rst_ni,
  set_stream_if.sink   in_i,
  set_stream_if.source out_o
);
  `SET_ASSERT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
  `SET_ASSERT(a_ready_free, clk_i, rst_ni, in_i.ready == (!out_o.valid || out_o.ready))
  `SET_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid)
endmodule

bind signal_edge_taper_top set_checker u_set_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import set_pkg::*;

  typedef struct {
    window_e          wtype;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] tlen;
  } taper_setting_t;

  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned HOLD_CYCLES    = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  set_stream_if #(.T(in_beat_t)) in_if ();
  set_stream_if #(.T(out_beat_t)) out_if ();

  signal_edge_taper_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  window_e          model_type;
  logic [LEN_W-1:0] model_rlen;
  logic [LEN_W-1:0] model_tlen;

  in_beat_t  sample_queue[$];
  out_beat_t tapered_queue[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned accepted;
  logic in_taken;
  logic hold_off;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned stall_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic longint unsigned ratio_coef(longint unsigned num, longint unsigned den);
    longint unsigned acc;
    longint unsigned rem;
    acc = num / den;
    rem = num % den;
    for (int i = 0; i <= COEF_F; i++) begin
      rem = rem << 1;
      acc = acc << 1;
      if (rem >= den) begin
        rem = rem - den;
        acc = acc | 64'd1;
      end
    end
    return (acc + 64'd1) >> 1;
  endfunction

  function automatic longint unsigned hann_coef(longint unsigned j, longint unsigned d);
    longint unsigned t;
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned s;
    longint sum;
    t = ((j << 30) + (d >> 1)) / d;
    ang = (t * 64'd1686629713 + (64'd1 << 29)) >> 30;
    ang2 = (ang * ang + (64'd1 << 29)) >> 30;
    term = ang;
    sum = longint'(ang);
    for (int k = 1; k <= 9; k++) begin
      term = (term * ang2 + (64'd1 << 29)) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = longint'(sum);
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    return (s * s + (64'd1 << (59 - COEF_F))) >> (60 - COEF_F);
  endfunction

  function automatic longint unsigned parzen_coef(longint unsigned j, longint unsigned d);
    longint unsigned d3;
    longint unsigned e;
    d3 = d * d * d;
    e = d - j;
    if (2 * j <= d) begin
      return ratio_coef(6 * j * j * e, d3);
    end
    return ratio_coef(d3 - 2 * e * e * e, d3);
  endfunction

  function automatic longint unsigned taper_coef(window_e wt, longint unsigned j,
                                                 longint unsigned len);
    case (wt)
      WIN_BARTLETT: return ratio_coef(j, len);
      WIN_HANN: return hann_coef(j, len + 1);
      default: return parzen_coef(j, len + 1);
    endcase
  endfunction

  function automatic longint apply_coef(longint x, longint unsigned c);
    longint unsigned mag;
    longint unsigned m;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    m = (mag * c + (64'd1 << (COEF_F - 1))) >> COEF_F;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic out_beat_t taper_sample(in_beat_t b);
    longint x;
    longint unsigned j;
    longint unsigned rl;
    longint unsigned ln;
    out_beat_t r;
    x = longint'(b.sample);
    j = b.position;
    rl = model_rlen;
    ln = model_tlen;
    if (rl > 65536) begin
      rl = 65536;
    end
    if (ln > rl) begin
      ln = rl;
    end
    if (model_type != WIN_NONE && ln > 0) begin
      if (j < ln) begin
        x = apply_coef(x, taper_coef(model_type, j, ln));
      end
      if (model_type != WIN_HANN && j < rl && j >= rl - ln) begin
        x = apply_coef(x, taper_coef(model_type, rl - 1 - j, ln));
      end
    end
    r.tapered_sample = x[SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
    $display("tb: mismatch %s got %0d expected %0d at cycle %0d", what, $signed(got),
             $signed(want), cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
        $display("tb: failure");
        $finish;
      end else begin
        in_taken <= in_if.valid && in_if.ready;
        if (in_if.valid && in_if.ready) begin
          tapered_queue.push_back(taper_sample(in_if.data));
          accepted <= accepted + 1;
        end
        if (out_if.valid && out_if.ready) begin
          if (tapered_queue.size() == 0) begin
            report("unexpected beat", out_if.data.tapered_sample, '0);
          end else if (out_if.data.tapered_sample !== tapered_queue[0].tapered_sample) begin
            report("tapered_sample", out_if.data.tapered_sample,
                   tapered_queue[0].tapered_sample);
            void'(tapered_queue.pop_front());
          end else begin
            void'(tapered_queue.pop_front());
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_if.data <= sample_queue.pop_front();
        in_if.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_count++;
      if (stall_count % 50 == 0) begin
        stall_mode = $urandom_range(0, 2);
      end
      out_if.ready <= !hold_off && (stall_mode == 0 ||
                      (stall_mode == 1 && $urandom_range(0, 1) == 1) ||
                      (stall_mode == 2 && $urandom_range(0, 3) == 0));
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (accepted >= 20);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_off = 1'b0;
  end

  task automatic wait_idle();
    wait (sample_queue.size() == 0 && !in_if.valid && tapered_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(taper_setting_t s);
    write_reg(CFG_WINDOW_TYPE, CFG_DATA_W'(s.wtype));
    write_reg(CFG_RECORD_LENGTH, s.rlen);
    write_reg(CFG_EDGE_SPAN, s.tlen);
    model_type = s.wtype;
    model_rlen = s.rlen;
    model_tlen = s.tlen;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(SAMPLE_W - 1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W - 1){1'b1}}};
      2: return SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(int unsigned rl, int unsigned ln);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (rl == 0 || r == 0) begin
      return POS_W'($urandom);
    end
    if (r <= 3) begin
      return POS_W'($urandom_range(0, (ln + 1 < rl) ? ln + 1 : rl - 1));
    end
    if (r <= 6) begin
      return POS_W'($urandom_range((rl > ln + 2) ? rl - ln - 2 : 0, rl - 1));
    end
    case ($urandom_range(0, 2))
      0: return '0;
      1: return POS_W'(rl - 1);
      default: return POS_W'(rl);
    endcase
  endfunction

  taper_setting_t settings[15];

  initial begin
    in_beat_t b;
    int unsigned rl;
    int unsigned ln;
    int unsigned n_items;
    errors = 0;
    cycles = 0;
    accepted = 0;
    in_taken = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_count = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    model_type = WIN_NONE;
    model_rlen = MAX_RECORD;
    model_tlen = '0;
    settings = '{
      '{WIN_BARTLETT, 17'd16, 17'd5}, '{WIN_HANN, 17'd16, 17'd5},
      '{WIN_PARZEN, 17'd16, 17'd5}, '{WIN_NONE, 17'd16, 17'd5},
      '{WIN_BARTLETT, 17'd10, 17'd10}, '{WIN_PARZEN, 17'd9, 17'd6},
      '{WIN_HANN, 17'd1, 17'd1}, '{WIN_BARTLETT, 17'd0, 17'd3},
      '{WIN_PARZEN, 17'd131071, 17'd65536}, '{WIN_HANN, 17'd65536, 17'd65536},
      '{WIN_BARTLETT, 17'd65536, 17'd0}, '{WIN_PARZEN, 17'd3, 17'd131071},
      '{WIN_BARTLETT, 17'd1000, 17'd400}, '{WIN_HANN, 17'd200, 17'd199},
      '{WIN_PARZEN, 17'd65536, 17'd300}
    };
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 8; i++) begin
      b.sample = (i % 2 == 0) ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
      b.position = (i < 4) ? '0 : '1;
      sample_queue.push_back(b);
    end
    wait_idle();

    foreach (settings[p]) begin
      apply_setting(settings[p]);
      rl = (settings[p].rlen > 65536) ? 65536 : settings[p].rlen;
      ln = (settings[p].tlen > rl) ? rl : settings[p].tlen;
      n_items = (p == 0) ? 100 : 25;
      for (int i = 0; i < n_items; i++) begin
        b.sample = pick_sample();
        b.position = pick_position(rl, ln);
        sample_queue.push_back(b);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
